/* src/a64dpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dpi_pkg
// shared types and constants of the immediate add/sub and wide move execute
// block
// ----------------------------------------------------------------------------
package a64dpi_pkg;

   localparam int REG_COUNT = 31;
   localparam int REG_AW    = 5;
   localparam int XLEN      = 64;
   localparam int INSN_W    = 32;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 80;

   localparam logic [REG_AW-1:0] ZERO_REG = 5'h1F;

   localparam logic [2:0] CLASS_ARITH = 3'h2;
   localparam logic [2:0] CLASS_WIDE  = 3'h5;

   localparam logic [1:0] OPC_MOVN = 2'b00;
   localparam logic [1:0] OPC_BAD  = 2'b01;
   localparam logic [1:0] OPC_MOVZ = 2'b10;
   localparam logic [1:0] OPC_MOVK = 2'b11;

   localparam logic [11:0] IMM12_MASK = 12'hFFF;
   localparam logic [15:0] IMM16_MASK = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_IMM  = 2'd1,
      STATUS_BAD_MOVE = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } wr_port_type;

   typedef struct packed {
      logic [REG_AW-1:0] dest_reg;
      logic [XLEN-1:0]   write_value;
      logic              wrote;
      logic [3:0]        flags_nzcv;
      status_type        status;
      logic              flags_upd;
   } exec_result_type;

   function automatic logic [REG_AW-1:0] src_index(input logic [INSN_W-1:0] insn);
      logic [REG_AW-1:0] idx;
      idx = (insn[25:23] == CLASS_ARITH) ? insn[9:5] : insn[4:0];
      return idx;
   endfunction

endpackage

/* src/a64dpi_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dpi_regfile
// general register memory, one registered read and one write per cycle,
// valid bits for reset to zero and a bypass for same-entry write and read
// ----------------------------------------------------------------------------
module a64dpi_regfile (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [a64dpi_pkg::REG_AW-1:0] rd_addr,
   input  a64dpi_pkg::wr_port_type     wr,
   output logic [a64dpi_pkg::XLEN-1:0] rd_data
);
   import a64dpi_pkg::*;

   logic [XLEN-1:0]      mem [0:REG_COUNT-1];
   logic [REG_COUNT-1:0] valid_ff;
   logic [XLEN-1:0]      mem_q_ff;
   logic                 hit_ok_ff;
   logic                 byp_ff;
   logic [XLEN-1:0]      byp_data_ff;
   logic                 rd_in_range;
   logic                 wr_in_range;
   logic                 byp_in;

   assign rd_in_range = (rd_addr != ZERO_REG);
   assign wr_in_range = wr.en && (wr.addr != ZERO_REG);
   assign byp_in      = wr_in_range && rd_in_range && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_in_range) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en && rd_in_range) begin
         mem_q_ff <= mem[rd_addr];
      end
      if (rd_en) begin
         byp_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         hit_ok_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (wr_in_range) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ok_ff <= rd_in_range && valid_ff[rd_addr];
            byp_ff    <= byp_in;
         end
      end
   end

   // write in the read cycle wins, unwritten entries read as zero
   assign rd_data = byp_ff ? byp_data_ff : (hit_ok_ff ? mem_q_ff : '0);

endmodule

/* src/a64dpi_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dpi_exec
// decode and execute of add/sub immediate and wide move, with nzcv flags
// ----------------------------------------------------------------------------
module a64dpi_exec (
   input  logic [a64dpi_pkg::INSN_W-1:0] insn,
   input  logic [a64dpi_pkg::XLEN-1:0]   src,
   input  logic [3:0]                    flags,
   output a64dpi_pkg::exec_result_type   res
);
   import a64dpi_pkg::*;

   logic            sf;
   logic [1:0]      opc;
   logic [2:0]      cls;
   logic [1:0]      hw;
   logic [XLEN-1:0] mask;
   logic [XLEN-1:0] a;
   logic [XLEN-1:0] imm;
   logic [XLEN-1:0] sum;
   logic [XLEN-1:0] ovf;
   logic [XLEN-1:0] field;
   logic [XLEN-1:0] wimm;
   logic [5:0]      sh;
   logic [5:0]      top;
   logic            sub;
   logic            n, z, c, v;
   logic [XLEN-1:0] value;
   status_type      st;

   always_comb begin
      sf    = insn[31];
      opc   = insn[30:29];
      cls   = insn[25:23];
      hw    = insn[22:21];
      mask  = sf ? {XLEN{1'b1}} : {{(XLEN-32){1'b0}}, {32{1'b1}}};
      a     = src & mask;
      sub   = opc[1];
      top   = sf ? 6'd63 : 6'd31;
      imm   = {{(XLEN-12){1'b0}}, insn[21:10] & IMM12_MASK};
      if (insn[22]) begin
         imm = imm << 12;
      end
      sum   = (sub ? (a - imm) : (a + imm)) & mask;
      n     = sum[top];
      z     = (sum == '0);
      c     = sub ? (a >= imm) : (sum < a);
      ovf   = sub ? ((a ^ imm) & (a ^ sum)) : (~(a ^ imm) & (a ^ sum));
      v     = ovf[top];
      sh    = {hw, 4'b0000};
      field = {{(XLEN-16){1'b0}}, IMM16_MASK} << sh;
      wimm  = {{(XLEN-16){1'b0}}, insn[15:0] & IMM16_MASK} << sh;
      value = '0;
      st    = STATUS_OK;

      if (cls == CLASS_ARITH) begin
         value = sum;
      end else if (cls == CLASS_WIDE) begin
         if ((opc == OPC_BAD) || (!sf && hw[1])) begin
            st = STATUS_BAD_MOVE;
         end else begin
            case (opc)
               OPC_MOVN: value = ~wimm & mask;
               OPC_MOVZ: value = wimm & mask;
               OPC_MOVK: value = ((a & ~field) | wimm) & mask;
               default:  value = '0;
            endcase
         end
      end else begin
         st = STATUS_NOT_IMM;
      end

      res.flags_upd   = (cls == CLASS_ARITH) && opc[0];
      res.flags_nzcv  = res.flags_upd ? {n, z, c, v} : flags;
      res.status      = st;
      res.dest_reg    = (st == STATUS_OK) ? insn[4:0] : '0;
      res.write_value = (st == STATUS_OK) ? value : '0;
      res.wrote       = (st == STATUS_OK) && (insn[4:0] != ZERO_REG);
   end

endmodule

/* src/arm64_dp_immediate_execute_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_dp_immediate_execute_top
// path: instruction and source register read are registered at the transfer
//          edge, then executed into the output register, which holds on a stall
// throughput: one instruction per cycle unless the output stalls, set by the
//          single register memory read port; dependents use the write bypass
// reset: synchronous; clears pipeline valids, flags and the 31 register
//          valid bits, so all registers read zero at once with no clear pass
// ----------------------------------------------------------------------------
module arm64_dp_immediate_execute_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [a64dpi_pkg::REQ_W-1:0] req_tdata,  // instruction[31:0]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // dest_reg[4:0], write_value[68:5], wrote[69], flags_nzcv[73:70],
   // status[75:74], zero[79:76]
   output logic [a64dpi_pkg::RSP_W-1:0] rsp_tdata
);
   import a64dpi_pkg::*;

   logic              s1_valid_ff;
   logic [INSN_W-1:0] s1_insn_ff;
   logic              out_valid_ff;
   exec_result_type   out_ff;
   logic [3:0]        flags_ff;
   logic              req_acc;
   logic              s1_adv;
   logic [XLEN-1:0]   src;
   exec_result_type   res;
   wr_port_type       wr;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   assign wr.en   = s1_adv && res.wrote;
   assign wr.addr = res.dest_reg;
   assign wr.data = res.write_value;

   a64dpi_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_addr (src_index(req_tdata[INSN_W-1:0])),
      .wr      (wr),
      .rd_data (src)
   );

   a64dpi_exec u_exec (
      .insn  (s1_insn_ff),
      .src   (src),
      .flags (flags_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_insn_ff <= req_tdata[INSN_W-1:0];
      end
      if (s1_adv) begin
         out_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_adv && res.flags_upd) begin
            flags_ff <= res.flags_nzcv;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.status, out_ff.flags_nzcv, out_ff.wrote,
                        out_ff.write_value, out_ff.dest_reg};

endmodule

/* src/a64dpi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dpi_checker
// port-level checks of the execute block, bound to the top level
// ----------------------------------------------------------------------------
module a64dpi_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [a64dpi_pkg::RSP_W-1:0] rsp_tdata
);
   import a64dpi_pkg::*;

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[75:74] <= STATUS_BAD_MOVE)
      else $error("bad status code");

   // no write reported for the zero register or a failed instruction
   a_wrote: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[69] |-> rsp_tdata[75:74] == STATUS_OK
                                      && rsp_tdata[4:0] != ZERO_REG)
      else $error("write reported without execution");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[75:74] != STATUS_OK |->
         rsp_tdata[68:0] == '0 && !rsp_tdata[69])
      else $error("failed instruction carries data");

endmodule

bind arm64_dp_immediate_execute_top a64dpi_checker u_checker (.*);
